@@ src/vss_pkg.sv @@
// Shared types and constants for the vector similarity score core.
package vss_pkg;
	localparam int MaxLength = 1024;
	localparam int AddrBits  = 10;
	localparam int LenBits   = 11;
	localparam int ElemBits  = 16;
	localparam int EnergyBits = 41;
	localparam int DotBits   = 42;
	localparam int RootBits  = 21;
	localparam int ScoreBits = 42;
	localparam int RowBits   = 16;

	localparam logic [1:0] StatusOk      = 2'd0;
	localparam logic [1:0] StatusZero    = 2'd1;
	localparam logic [1:0] StatusNoQuery = 2'd2;

	localparam logic [0:0] RegLength = 1'b0;
	localparam logic [0:0] RegMode   = 1'b1;

	// row or query summary handed from the front part to the back part
	typedef struct packed {
		logic                         is_query;
		logic                         qready;
		logic                         mode;
		logic signed [DotBits-1:0]    dot;
		logic [EnergyBits-1:0]        energy;
		logic [RowBits-1:0]           row;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_ROOT, BK_MUL, BK_DIV, BK_OUT
	} bk_state_t;
endpackage

@@ src/vss_front.sv @@
// Front part: query store, dot and energy accumulation, row classification.
module vss_front import vss_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       operation,
	input  logic signed [ElemBits-1:0] element,
	input  logic [LenBits-1:0]         len_q,
	input  logic                       mode_q,
	input  logic                       job_ready,
	output logic                       job_valid,
	output job_t                       job
);
	logic signed [ElemBits-1:0] mem [MaxLength];
	logic signed [ElemBits-1:0] qrd_s1, elem_s1;
	logic                       v_s1, kind_s1, first_s1, last_s1;
	logic [LenBits-1:0]         pos_q, eff_len;
	logic                       kind_q, qready_q;
	logic [RowBits-1:0]         row_q;
	logic signed [DotBits-1:0]  dot_q;
	logic [EnergyBits-1:0]      renergy_q, qenergy_q;
	logic [LenBits-1:0]         pos_eff, pos_next;
	logic                       accept, last, push;
	logic signed [2*ElemBits-1:0] prod, sq;
	logic [EnergyBits-1:0]      en_base, en_new;
	logic signed [DotBits-1:0]  dot_base, dot_new;

	// queue of two job slots
	job_t  fifo_q [2];
	logic  wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign eff_len = (len_q == '0) ? LenBits'(1) :
		(len_q > LenBits'(MaxLength)) ? LenBits'(MaxLength) : len_q;
	// hold input while the queue is full or about to fill, so it can always take a job from stage 1
	assign in_ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !push);
	assign accept   = in_valid && in_ready;
	assign pos_eff  = (operation != kind_q) ? '0 : pos_q;
	assign pos_next = LenBits'({1'b0, pos_eff[AddrBits-1:0]}) + LenBits'(1);
	assign last     = pos_next >= eff_len;

	always_ff @(posedge clk) begin
		if (accept && !operation)
			mem[pos_eff[AddrBits-1:0]] <= element;
		qrd_s1  <= mem[pos_eff[AddrBits-1:0]];
		elem_s1 <= element;
		first_s1 <= pos_eff[AddrBits-1:0] == '0;
		last_s1 <= last;
		kind_s1 <= operation;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			pos_q  <= '0;
			kind_q <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				kind_q <= operation;
				pos_q  <= last ? '0 : pos_next;
			end
		end
	end

	assign prod     = qrd_s1 * elem_s1;
	assign sq       = elem_s1 * elem_s1;
	assign en_base  = first_s1 ? '0 : (kind_s1 ? renergy_q : qenergy_q);
	assign en_new   = en_base + EnergyBits'($unsigned(sq));
	assign dot_base = first_s1 ? '0 : dot_q;
	assign dot_new  = dot_base + DotBits'(prod);

	assign push = v_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qenergy_q <= '0;
			renergy_q <= '0;
			dot_q     <= '0;
			qready_q  <= 1'b0;
			row_q     <= '0;
		end else if (v_s1) begin
			if (kind_s1) begin
				dot_q     <= dot_new;
				renergy_q <= en_new;
				if (last_s1) row_q <= row_q + RowBits'(1);
			end else begin
				qenergy_q <= en_new;
				qready_q  <= last_s1;
				if (last_s1) row_q <= '0;
			end
		end
	end

	// jobs: query completion (root needed) and row completion
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].is_query <= !kind_s1;
			fifo_q[wr_ptr_q].qready   <= qready_q;
			fifo_q[wr_ptr_q].mode     <= mode_q;
			fifo_q[wr_ptr_q].dot      <= dot_new;
			fifo_q[wr_ptr_q].energy   <= en_new;
			fifo_q[wr_ptr_q].row      <= row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (job_valid && job_ready) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(job_valid && job_ready);
		end
	end

	assign job_valid = cnt_q != 2'd0;
	assign job       = fifo_q[rd_ptr_q];
endmodule

@@ src/vss_back.sv @@
// Back part: query root, row root, scaled division and result register.
module vss_back import vss_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	output logic                        job_ready,
	input  job_t                        job,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [ScoreBits-1:0] score,
	output logic [1:0]                  status,
	output logic [RowBits-1:0]          row_number
);
	bk_state_t state_q, state_d;
	job_t      job_q;
	logic [RootBits-1:0]   qroot_q, rroot_q;
	logic [EnergyBits-1:0] qenergy_q;
	// shared root unit: one root bit per cycle step
	logic [EnergyBits+1:0] rx_q;
	logic [RootBits-1:0]   rres_q;
	logic [4:0]            rcnt_q;
	logic [2*RootBits-1:0] den_q;
	logic [DotBits-1:0]    mag_q;
	logic [DotBits:0]      rem_q;
	logic [16:0]           quo_q;
	logic [5:0]            dcnt_q;
	logic                  neg_q;

	logic [RootBits+1:0]   trial;
	logic [DotBits:0]      rem_sh;
	logic                  rdone, ddone, dfit;

	assign job_ready = state_q == BK_IDLE;
	assign trial  = {rres_q, 2'b01};
	assign rdone  = rcnt_q == 5'd0;
	assign rem_sh = {rem_q[DotBits-1:0], mag_q[DotBits-1]};
	assign dfit   = rem_sh >= (DotBits+1)'(den_q);
	assign ddone  = dcnt_q == 6'd0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (job_valid) state_d = BK_ROOT;
			BK_ROOT: if (rdone) state_d = job_q.is_query ? BK_IDLE : BK_MUL;
			BK_MUL:  state_d = BK_DIV;
			BK_DIV:  if (ddone) state_d = BK_OUT;
			BK_OUT:  if (!out_valid || out_ready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// remainder-restoring root over a 42-bit radicand, 21 steps
	logic [EnergyBits+1:0] rad_sh;
	assign rad_sh = {rx_q[EnergyBits-1:0], 2'b00};

	logic [RootBits+1:0] racc_q;
	logic [RootBits+1:0] racc_sh;
	logic                rfit;
	assign racc_sh = {racc_q[RootBits-1:0], rx_q[EnergyBits+1:EnergyBits]};
	assign rfit    = racc_sh >= trial;

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: if (job_valid) begin
				job_q  <= job;
				// align the last bit pair with energy bit 0
				rx_q   <= {1'b0, job.energy, 1'b0};
				rres_q <= '0;
				racc_q <= '0;
				rcnt_q <= 5'(RootBits);
			end
			BK_ROOT: if (!rdone) begin
				rx_q   <= rad_sh;
				racc_q <= rfit ? racc_sh - trial : racc_sh;
				rres_q <= {rres_q[RootBits-2:0], rfit};
				rcnt_q <= rcnt_q - 5'd1;
			end else if (job_q.is_query) begin
				qroot_q   <= rres_q;
				qenergy_q <= job_q.energy;
			end else
				rroot_q <= rres_q;
			BK_MUL: begin
				den_q  <= qroot_q * rroot_q;
				neg_q  <= job_q.dot[DotBits-1];
				mag_q  <= job_q.dot[DotBits-1] ? DotBits'(-job_q.dot) : DotBits'(job_q.dot);
				rem_q  <= '0;
				quo_q  <= '0;
				dcnt_q <= 6'(DotBits + 15);
			end
			BK_DIV: if (!ddone) begin
				// long division of mag*2^15 by den, one bit per cycle
				mag_q <= {mag_q[DotBits-2:0], 1'b0};
				rem_q <= dfit ? rem_sh - (DotBits+1)'(den_q) : rem_sh;
				// pin the top bit once the quotient reaches 2^16
				quo_q <= (quo_q[16] || (dcnt_q > 6'd16 && dfit)) ? 17'h10000 :
					{quo_q[15:0], dfit};
				dcnt_q <= dcnt_q - 6'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else         state_q <= state_d;
	end

	logic signed [ScoreBits-1:0] cos;
	always_comb begin
		if (quo_q[16] || quo_q > 17'd32768)
			cos = neg_q ? -ScoreBits'(32768) : ScoreBits'(32767);
		else if (neg_q)
			cos = -ScoreBits'(quo_q);
		else
			cos = (quo_q > 17'd32767) ? ScoreBits'(32767) : ScoreBits'(quo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (state_q == BK_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_OUT && (!out_valid || out_ready)) begin
			row_number <= job_q.row;
			if (!job_q.qready) begin
				score <= '0; status <= StatusNoQuery;
			end else if (!job_q.mode) begin
				score <= job_q.dot; status <= StatusOk;
			end else if (qenergy_q == '0 || job_q.energy == '0) begin
				score <= '0; status <= StatusZero;
			end else begin
				score <= cos; status <= StatusOk;
			end
		end
	end
endmodule

@@ src/vector_similarity_score_core.sv @@
// A row result passes stage 1 and the two-entry queue, then the root, product and divide
// steps, then the result register.
// Throughput: elements at one per cycle while the two-entry queue has room; the back part
// takes one job at a time: rows through the bit-serial root and divider, query completions through the root alone.
// Reset: asynchronous, active low; clears control, sums, flags and queue; query store
// is not cleared; vector_length resets to 1024 and score_mode to cosine.
module vector_similarity_score_core import vss_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        operation,
	input  logic signed [ElemBits-1:0]  element,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [ScoreBits-1:0] score,
	output logic [1:0]                  status,
	output logic [RowBits-1:0]          row_number,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [LenBits-1:0]          cfg_data
);
	logic [LenBits-1:0] len_q;
	logic               mode_q;
	logic               job_valid, job_ready;
	job_t               job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LenBits'(MaxLength);
			mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				RegLength: len_q  <= cfg_data;
				RegMode:   mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	vss_front u_front (.clk, .arst_n, .in_valid, .in_ready, .operation, .element,
		.len_q, .mode_q, .job_ready, .job_valid, .job);
	vss_back u_back (.clk, .arst_n, .job_valid, .job_ready, .job, .out_valid,
		.out_ready, .score, .status, .row_number);

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= StatusNoQuery) else $error("bad status");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(score)) else $error("result lost");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != StatusOk |-> score == '0) else $error("nonzero flagged score");
endmodule
